[src/dnle_pkg.sv]
`default_nettype none
package dnle_pkg;

  localparam int unsigned LABEL_MAX_DEF  = 63;
  localparam int unsigned WORD_BYTES_DEF = 8;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CAP_W       = 16;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CAP_W-1:0]  CAP_RESET = 16'd512;
  localparam logic [CHAR_W-1:0] ASCII_DOT = 8'h2E;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LONG     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

  // one request from the sequencer to the word packer
  typedef struct packed {
    logic                push;
    logic                is_err;
    logic [CHAR_W-1:0]   data;
    logic                last;
    logic                fin;
    logic [STATUS_W-1:0] status;
  } pk_req_t;

endpackage
`default_nettype wire

[src/dnle_packer.sv]
`default_nettype none
module dnle_packer
  import dnle_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pk_req_t                req_i,
  output logic                        ready_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // word_data[63:0], bytes_valid[67:64]
  output logic                        m_axis_tlast,   // final_word
  output logic [STATUS_W-1:0]         m_axis_tuser    // status
);

  localparam int unsigned CW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int unsigned AW_BITS = WORD_BYTES * CHAR_W;

  logic [AW_BITS-1:0]  acc_q, acc_d, acc_word;
  logic [CW-1:0]       acc_cnt_q, acc_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_data_q, out_data_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;
  logic                out_last_q, out_last_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  assign ready_o = !out_valid_q || m_axis_tready;

  // insert the new byte at the fill position
  always_comb begin
    acc_word = acc_q;
    for (int i = 0; i < int'(WORD_BYTES); i++) begin
      if (acc_cnt_q == CW'(i)) begin
        acc_word[i*CHAR_W +: CHAR_W] = req_i.data;
      end
    end
  end

  always_comb begin
    acc_d        = acc_q;
    acc_cnt_d    = acc_cnt_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (req_i.push && ready_o) begin
      if (req_i.is_err) begin
        out_valid_d  = 1'b1;
        out_data_d   = '0;
        out_cnt_d    = '0;
        out_last_d   = 1'b1;
        out_status_d = req_i.status;
      end else if (acc_cnt_q == CW'(WORD_BYTES - 1) || req_i.last) begin
        out_valid_d  = 1'b1;
        out_data_d   = WORD_W'(acc_word);
        out_cnt_d    = CNT_W'(acc_cnt_q) + CNT_W'(1);
        out_last_d   = req_i.fin;
        out_status_d = STATUS_OK;
        acc_d        = '0;
        acc_cnt_d    = '0;
      end else begin
        acc_d     = acc_word;
        acc_cnt_d = acc_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - CNT_W)'(0), out_cnt_q, out_data_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire

[src/dns_name_label_encoder_top.sv]
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata character, tlast name_end
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata word_data+bytes_valid, tlast final_word,
//          |     |                              | tuser status
// cfg      | in  | cfg_we_i                     | cfg_wdata_i output_capacity
// A label character is stored and the next item can be taken in the following cycle.
// A dot or end item passes a planning state, then streams its wire bytes (length byte,
// label bytes from the memory read port, root byte), then an error item if one is due.
// Output stalls hold the byte stream; a finished word waits in the output register.
// Reset clears the sequencer, counters and capacity (512); the label memory is not cleared.
`default_nettype none
module dns_name_label_encoder_top
  import dnle_pkg::*;
#(
  parameter int unsigned LABEL_MAX  = LABEL_MAX_DEF,
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_W-1:0]       cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // character[7:0]
  input  wire logic                   s_axis_tlast,   // name_end
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // word_data[63:0], bytes_valid[67:64]
  output logic                        m_axis_tlast,   // final_word
  output logic [STATUS_W-1:0]         m_axis_tuser    // status
);

  localparam int unsigned LW = $clog2(LABEL_MAX + 1);
  localparam int unsigned AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int unsigned KW = $clog2(LABEL_MAX + 3);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [LW-1:0]       len_q, len_d;
  logic [CAP_W-1:0]    bw_q, bw_d;
  logic                failed_q, failed_d;
  logic                end_q, end_d;
  logic                err_q, err_d;
  logic [STATUS_W-1:0] errc_q, errc_d;
  logic [KW-1:0]       nb_q, nb_d;
  logic [KW-1:0]       k_q, k_d;

  logic [CHAR_W-1:0]   mem_q [LABEL_MAX];
  logic [CHAR_W-1:0]   rd_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  logic                in_acc, is_dot, pk_rdy, last_byte;
  logic [CAP_W:0]      avail_w;
  logic [CAP_W-1:0]    avail, len16;
  logic [KW-1:0]       nb_new;
  logic                err_new;
  pk_req_t             pk_req;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_dot        = (s_axis_tdata[CHAR_W-1:0] == ASCII_DOT);
  assign mem_we        = in_acc && !s_axis_tlast && !failed_q && !is_dot
                         && (len_q < LW'(LABEL_MAX));

  // room left in this name; a capacity lowered below the count leaves none
  assign avail_w = {1'b0, cap_q} - {1'b0, bw_q};
  assign avail   = avail_w[CAP_W] ? '0 : avail_w[CAP_W-1:0];
  assign len16   = CAP_W'(len_q);

  always_comb begin
    nb_new  = '0;
    err_new = 1'b0;
    if (len_q == '0) begin
      if (end_q) begin
        if (avail >= CAP_W'(1)) begin
          nb_new = KW'(1);
        end else begin
          err_new = 1'b1;
        end
      end
    end else if (avail < CAP_W'(1)) begin
      err_new = 1'b1;
    end else if (avail < len16 + CAP_W'(1)) begin
      nb_new  = KW'(1);
      err_new = 1'b1;
    end else begin
      nb_new = KW'(len_q) + KW'(1);
      if (end_q) begin
        if (avail >= len16 + CAP_W'(2)) begin
          nb_new = KW'(len_q) + KW'(2);
        end else begin
          err_new = 1'b1;
        end
      end
    end
  end

  assign last_byte = (k_q == nb_q - KW'(1));

  always_comb begin
    pk_req        = '0;
    pk_req.status = errc_q;
    if (state_q == ST_EMIT) begin
      pk_req.push = 1'b1;
      pk_req.last = last_byte;
      pk_req.fin  = last_byte && end_q && !err_q;
      if (k_q == '0) begin
        pk_req.data = CHAR_W'(len_q);
      end else if (k_q <= KW'(len_q)) begin
        pk_req.data = rd_q;
      end else begin
        pk_req.data = '0;
      end
    end else if (state_q == ST_ERR) begin
      pk_req.push   = 1'b1;
      pk_req.is_err = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    bw_d     = bw_q;
    failed_d = failed_q;
    end_d    = end_q;
    err_d    = err_q;
    errc_d   = errc_q;
    nb_d     = nb_q;
    k_d      = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            if (failed_q) begin
              len_d    = '0;
              bw_d     = '0;
              failed_d = 1'b0;
            end else begin
              end_d   = 1'b1;
              state_d = ST_PLAN;
            end
          end else if (!failed_q) begin
            if (is_dot) begin
              end_d   = 1'b0;
              state_d = ST_PLAN;
            end else if (mem_we) begin
              len_d = len_q + LW'(1);
            end else begin
              end_d   = 1'b0;
              err_d   = 1'b1;
              errc_d  = STATUS_LONG;
              state_d = ST_ERR;
            end
          end
        end
      end
      ST_PLAN: begin
        nb_d   = nb_new;
        err_d  = err_new;
        errc_d = STATUS_CAPACITY;
        bw_d   = bw_q + CAP_W'(nb_new);
        k_d    = '0;
        if (nb_new != '0) begin
          state_d = ST_EMIT;
        end else if (err_new) begin
          state_d = ST_ERR;
        end else begin
          state_d = ST_IDLE;
          if (end_q) begin
            len_d = '0;
            bw_d  = '0;
          end
        end
      end
      ST_EMIT: begin
        if (pk_rdy) begin
          k_d = k_q + KW'(1);
          if (last_byte) begin
            if (err_q) begin
              state_d = ST_ERR;
            end else begin
              state_d = ST_IDLE;
              len_d   = '0;
              if (end_q) begin
                bw_d = '0;
              end
            end
          end
        end
      end
      ST_ERR: begin
        if (pk_rdy) begin
          state_d = ST_IDLE;
          err_d   = 1'b0;
          if (end_q) begin
            len_d = '0;
            bw_d  = '0;
          end else begin
            failed_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cap_q    <= CAP_RESET;
      len_q    <= '0;
      bw_q     <= '0;
      failed_q <= 1'b0;
      end_q    <= 1'b0;
      err_q    <= 1'b0;
      errc_q   <= STATUS_OK;
      nb_q     <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      len_q    <= len_d;
      bw_q     <= bw_d;
      failed_q <= failed_d;
      end_q    <= end_d;
      err_q    <= err_d;
      errc_q   <= errc_d;
      nb_q     <= nb_d;
      k_q      <= k_d;
    end
  end

  // label memory: read one ahead of the byte position, hold while stalled
  assign rd_addr = AW'(k_d - KW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[len_q[AW-1:0]] <= s_axis_tdata[CHAR_W-1:0];
    end
    rd_q <= mem_q[rd_addr];
  end

  dnle_packer #(
    .WORD_BYTES (WORD_BYTES)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (pk_req),
    .ready_o       (pk_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < nb_q))
    else $error("byte position beyond planned count");

  a_fail_from_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(failed_q) |-> ($past(state_q) == ST_ERR))
    else $error("name marked failed without an error item");

  a_empty_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[67:64] == 4'd0))
      |-> (m_axis_tlast && (m_axis_tuser != STATUS_OK)))
    else $error("empty word without error status");

endmodule
`default_nettype wire
